FILE: hw/rtl/periodic_flag_scheduler_unit_assert.svh
// Assertion macros shared by the periodic flag scheduler RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef PERIODIC_FLAG_SCHEDULER_UNIT_ASSERT_SVH
`define PERIODIC_FLAG_SCHEDULER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// checked property, masked while reset is low
`define PFS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pfs assertion failed");
// checked property, live through reset too
`define PFS_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pfs reset assertion failed");
`else
`define PFS_ASSERT(label, clk, rst_n, prop)
`define PFS_ASSERT_RST(label, clk, prop)
`endif

`endif

FILE: hw/rtl/pfs_pkg.sv
// Shared constants, codes and types of the periodic flag scheduler.
// No dependencies; used by pfs_engine and the top level.
package pfs_pkg;

  localparam int NUM_FLAGS = 16;
  // id and mask are 4 and 16 bits wide, so at most 16 slots are usable
  localparam int CAPACITY  = (NUM_FLAGS < 16) ? NUM_FLAGS : 16;
  localparam int SLOT_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int VAL_W     = 16;
  localparam int MASK_W    = 16;
  localparam int ID_W      = 4;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_CREATE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_REARM  = 2'd3;

  localparam logic [1:0] ST_UNUSED  = 2'd0;
  localparam logic [1:0] ST_ARMED   = 2'd1;
  localparam logic [1:0] ST_PENDING = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic [MASK_W-1:0] pending_mask;
    logic [ID_W-1:0]   new_id;
    logic [1:0]        timer_state;
    logic [1:0]        status;
  } res_t;

endpackage

FILE: hw/rtl/pfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/pfs_engine.sv
// Command sequencer: slot states, allocation count, and the tick sweep that
// read-modify-writes period/countdown pairs. Uses pfs_pkg and pfs_ram.
`include "periodic_flag_scheduler_unit_assert.svh"

module pfs_engine (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  logic [1:0]               cmd,
  input  logic [pfs_pkg::ID_W-1:0] flag_id,
  input  logic [pfs_pkg::VAL_W-1:0] interval,
  output logic                     res_valid,
  input  logic                     res_ready,
  output pfs_pkg::res_t            res
);

  localparam int SLOT_W = pfs_pkg::SLOT_W;
  localparam int CNT_W  = pfs_pkg::CNT_W;
  localparam int VAL_W  = pfs_pkg::VAL_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SWEEP = 4'b0010,
    S_LAST  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]  slots_used_r, slots_used_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [SLOT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [1:0]        slot_st_r   [pfs_pkg::CAPACITY];
  logic [1:0]        slot_st_nxt [pfs_pkg::CAPACITY];
  logic [1:0]        status_r, status_nxt;
  logic [1:0]        fstate_r, fstate_nxt;
  logic [pfs_pkg::ID_W-1:0] nid_r, nid_nxt;

  logic              item_fire;
  logic              full;
  logic              id_ok;
  logic              last_slot;
  logic              create_ok;
  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  logic [2*VAL_W-1:0] ram_wdata, ram_rdata;
  logic [VAL_W-1:0]  rd_period, rd_count;
  logic [pfs_pkg::MASK_W-1:0] mask;

  assign item_ready = (state_r == S_IDLE);
  assign item_fire  = item_valid && item_ready;
  assign full       = (slots_used_r == CNT_W'(pfs_pkg::CAPACITY));
  assign id_ok      = (CNT_W'(flag_id) < slots_used_r) &&
                      (32'(flag_id) < pfs_pkg::CAPACITY);
  assign last_slot  = (CNT_W'(idx_r) == slots_used_r - CNT_W'(1));
  assign create_ok  = item_fire && (cmd == pfs_pkg::CMD_CREATE) && !full;
  assign rd_period  = ram_rdata[2*VAL_W-1:VAL_W];
  assign rd_count   = ram_rdata[VAL_W-1:0];

  pfs_ram #(
    .WIDTH (2*VAL_W),
    .DEPTH (pfs_pkg::CAPACITY)
  ) u_timer_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    slots_used_nxt = slots_used_r;
    idx_nxt        = idx_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    slot_st_nxt    = slot_st_r;
    status_nxt     = status_r;
    fstate_nxt     = fstate_r;
    nid_nxt        = nid_r;
    ram_we         = 1'b0;
    ram_waddr      = rd_idx_r;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = idx_r;

    // sweep write-back: slot read last cycle, updated this cycle
    if (rd_vld_r && (slot_st_r[rd_idx_r] == pfs_pkg::ST_ARMED)) begin
      ram_we = 1'b1;
      if (rd_count != '0) begin
        ram_wdata = {rd_period, rd_count - VAL_W'(1)};
      end else begin
        ram_wdata = {rd_period, rd_period};
        slot_st_nxt[rd_idx_r] = pfs_pkg::ST_PENDING;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (item_fire) begin
          status_nxt = pfs_pkg::STATUS_OK;
          fstate_nxt = pfs_pkg::ST_UNUSED;
          nid_nxt    = '0;
          state_nxt  = S_DONE;
          case (cmd)
            pfs_pkg::CMD_TICK: begin
              idx_nxt = '0;
              if (slots_used_r != '0) begin
                state_nxt = S_SWEEP;
              end
            end
            pfs_pkg::CMD_CREATE: begin
              if (full) begin
                status_nxt = pfs_pkg::STATUS_FULL;
              end else begin
                ram_we         = 1'b1;
                ram_waddr      = SLOT_W'(slots_used_r);
                ram_wdata      = {interval, interval};
                slot_st_nxt[SLOT_W'(slots_used_r)] = pfs_pkg::ST_ARMED;
                slots_used_nxt = slots_used_r + CNT_W'(1);
                nid_nxt        = pfs_pkg::ID_W'(slots_used_r);
              end
            end
            pfs_pkg::CMD_READ: begin
              if (id_ok) begin
                fstate_nxt = slot_st_r[SLOT_W'(flag_id)];
              end else begin
                status_nxt = pfs_pkg::STATUS_NOT_FOUND;
              end
            end
            pfs_pkg::CMD_REARM: begin
              if (id_ok) begin
                slot_st_nxt[SLOT_W'(flag_id)] = pfs_pkg::ST_ARMED;
              end else begin
                status_nxt = pfs_pkg::STATUS_NOT_FOUND;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SWEEP: begin
        ram_re     = 1'b1;
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = idx_r;
        if (last_slot) begin
          state_nxt = S_LAST;
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end
      S_LAST: begin
        // last write-back happens this cycle
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    mask = '0;
    for (int i = 0; i < pfs_pkg::CAPACITY; i++) begin
      mask[i] = (slot_st_r[i] == pfs_pkg::ST_PENDING);
    end
  end

  assign res_valid        = (state_r == S_DONE);
  assign res.status       = status_r;
  assign res.timer_state  = fstate_r;
  assign res.new_id       = nid_r;
  assign res.pending_mask = mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slots_used_r <= '0;
      idx_r        <= '0;
      rd_vld_r     <= 1'b0;
      for (int i = 0; i < pfs_pkg::CAPACITY; i++) begin
        slot_st_r[i] <= pfs_pkg::ST_UNUSED;
      end
    end else begin
      state_r      <= state_nxt;
      slots_used_r <= slots_used_nxt;
      idx_r        <= idx_nxt;
      rd_vld_r     <= rd_vld_nxt;
      slot_st_r    <= slot_st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    status_r <= status_nxt;
    fstate_r <= fstate_nxt;
    nid_r    <= nid_nxt;
  end

  `PFS_ASSERT(a_used_in_range, clk, rst_n, slots_used_r <= CNT_W'(pfs_pkg::CAPACITY))
  `PFS_ASSERT(a_sweep_allocated, clk, rst_n, rd_vld_r |-> (CNT_W'(rd_idx_r) < slots_used_r))
  `PFS_ASSERT(a_no_rw_overlap, clk, rst_n, (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
  `PFS_ASSERT(a_create_count, clk, rst_n, create_ok |=> slots_used_r == $past(slots_used_r) + CNT_W'(1))
  `PFS_ASSERT(a_done_drained, clk, rst_n, (state_r == S_DONE) |-> !rd_vld_r)
  `PFS_ASSERT_RST(a_reset_idle, clk, !rst_n |=> (state_r == S_IDLE && !rd_vld_r))

endmodule

FILE: hw/rtl/periodic_flag_scheduler_unit.sv
// Top level of the periodic flag scheduler: stream ports and output register.
// Uses pfs_pkg and pfs_engine (which holds the timer RAM).
//
//   port group | dir | tdata / tuser contents (low bit first)
//   in_*       | in  | tuser: command[1:0]; tdata: flag_id[3:0], interval[19:4], 0[23:20]
//   out_*      | out | tdata: status[1:0], timer_state[3:2], new_id[7:4], pending_mask[23:8]
//
// Create, read and re-arm: the result is registered in the engine on accept, then moves to the output register.
// Tick over the allocated slots: the sweep reads one
// slot per cycle from the timer RAM and writes it back the next cycle.
// Reset clears slot states and the allocation count; the RAM needs no clearing.
// A new word is taken while the previous result waits in the output register.
module periodic_flag_scheduler_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // flag_id[3:0], interval[19:4], zero[23:20]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // status, timer_state, new_id, pending_mask
);

  logic          res_valid;
  logic          res_ready;
  pfs_pkg::res_t res;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [23:0]   out_tdata_r;

  pfs_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .cmd        (in_tuser),
    .flag_id    (in_tdata[3:0]),
    .interval   (in_tdata[19:4]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (res_valid && res_ready) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_tdata_r <= {res.pending_mask, res.new_id, res.timer_state, res.status};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
